// ----- rtl/srtrb_pkg.sv -----
package srtrb_pkg;

	// Ring depths and the widths that follow from them
	localparam int RX_DEPTH = 64;
	localparam int TX_DEPTH = 64;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_TRANSMIT_ENABLE = REG_IDX_W'(0);

	// Error flag bits
	localparam logic [2:0] ERR_FRAMING = 3'b001;
	localparam logic [2:0] ERR_LINE    = 3'b010;
	localparam logic [2:0] ERR_SOFT    = 3'b100;

	typedef enum logic [1:0] {
		OP_RX_BYTE    = 2'd0,
		OP_HOST_READ  = 2'd1,
		OP_HOST_WRITE = 2'd2,
		OP_TX_READY   = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       framing_error;
		logic       line_overrun;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       read_byte;
		logic             read_valid;
		logic [7:0]       send_byte;
		logic             send_valid;
		logic             write_accepted;
		logic             write_full;
		logic             transmit_irq_on;
		logic             receive_available;
		logic [RX_CW-1:0] receive_level;
		logic [2:0]       error_flags;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic load;
	} ctrl_cmd_t;

endpackage

// ----- rtl/srtrb_if.sv -----
interface srtrb_in_if;
	logic             valid;
	logic             ready;
	srtrb_pkg::op_t   op;
	logic [7:0]       data_byte;
	logic             framing_error;
	logic             line_overrun;

	modport source (output valid, op, data_byte, framing_error, line_overrun, input ready);
	modport sink (input valid, op, data_byte, framing_error, line_overrun, output ready);
endinterface

interface srtrb_out_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  read_byte;
	logic                        read_valid;
	logic [7:0]                  send_byte;
	logic                        send_valid;
	logic                        write_accepted;
	logic                        write_full;
	logic                        transmit_irq_on;
	logic                        receive_available;
	logic [srtrb_pkg::RX_CW-1:0] receive_level;
	logic [2:0]                  error_flags;

	modport source (output valid, read_byte, read_valid, send_byte, send_valid,
		write_accepted, write_full, transmit_irq_on, receive_available,
		receive_level, error_flags, input ready);
	modport sink (input valid, read_byte, read_valid, send_byte, send_valid,
		write_accepted, write_full, transmit_irq_on, receive_available,
		receive_level, error_flags, output ready);
endinterface

// ----- rtl/serial_rx_tx_ring_buffers.sv -----
// Receive and transmit ring buffers of a serial port.
// in_ch carries one event per transaction: a received byte with its line
// status, a host read, a host write or a transmitter-ready strobe, chosen
// by op. out_ch returns exactly one result per event, in order, with the
// read or sent byte, the write outcome and the ring status after the event.
// The accepting edge updates the pointers and reads the ring; the output
// register loads from the ring read once it is free. Throughput: one event
// per cycle while out_ch is drained; the rate is set by the single output
// register behind the ring read port.
// When out_ch stalls, one more event is taken and then in_ch holds ready low
// until the waiting result is taken.
// The APB port holds transmit_enable at byte address 0; pready is always high.
// Reset (arst_n low) empties both rings, clears the error flags and the
// transmit interrupt enable, and sets transmit_enable. Ring contents are not
// cleared; the pointers never reach unwritten entries.
module serial_rx_tx_ring_buffers (
	input  logic                          clk,
	input  logic                          arst_n,
	srtrb_in_if.sink                      in_ch,
	srtrb_out_if.source                   out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srtrb_pkg::PADDR_W-1:0] paddr,
	input  logic [srtrb_pkg::PDATA_W-1:0] pwdata,
	output logic [srtrb_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);

	localparam int PADDR_W = srtrb_pkg::PADDR_W;
	localparam int PDATA_W = srtrb_pkg::PDATA_W;

	logic                 transmit_enable_q;
	logic                 reg_hit;
	srtrb_pkg::ctrl_cmd_t cmd;
	srtrb_pkg::in_item_t  item;
	srtrb_pkg::out_item_t result;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == srtrb_pkg::REG_TRANSMIT_ENABLE);
	assign prdata  = reg_hit ? {{(PDATA_W-1){1'b0}}, transmit_enable_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transmit_enable_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			transmit_enable_q <= pwdata[0];
		end
	end

	// Gather the input payload
	assign item.op            = in_ch.op;
	assign item.data_byte     = in_ch.data_byte;
	assign item.framing_error = in_ch.framing_error;
	assign item.line_overrun  = in_ch.line_overrun;

	srtrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	srtrb_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.item            (item),
		.transmit_enable (transmit_enable_q),
		.result          (result)
	);

	// Spread the result over the output channel
	assign out_ch.read_byte         = result.read_byte;
	assign out_ch.read_valid        = result.read_valid;
	assign out_ch.send_byte         = result.send_byte;
	assign out_ch.send_valid        = result.send_valid;
	assign out_ch.write_accepted    = result.write_accepted;
	assign out_ch.write_full        = result.write_full;
	assign out_ch.transmit_irq_on   = result.transmit_irq_on;
	assign out_ch.receive_available = result.receive_available;
	assign out_ch.receive_level     = result.receive_level;
	assign out_ch.error_flags       = result.error_flags;

endmodule

// ----- rtl/srtrb_ctrl.sv -----
module srtrb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_ready,
	output logic                 in_ready,
	output logic                 out_valid,
	output srtrb_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOAD = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Output register may take a new result when empty or being drained
	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE) || ((state_q == ST_LOAD) && out_free);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.load   = (state_q == ST_LOAD) && out_free;
	assign out_valid  = out_valid_q;

	// Sequence: accept updates state and reads memory, load fills the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (cmd.load && !cmd.accept) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_LOAD))
		else $error("accepted item did not reach the load state");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("load did not raise output valid");
	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOAD) && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while a result was still waiting");
`endif

endmodule

// ----- rtl/srtrb_datapath.sv -----
module srtrb_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srtrb_pkg::ctrl_cmd_t  cmd,
	input  srtrb_pkg::in_item_t   item,
	input  logic                  transmit_enable,
	output srtrb_pkg::out_item_t  result
);

	localparam int RX_AW = srtrb_pkg::RX_AW;
	localparam int TX_AW = srtrb_pkg::TX_AW;
	localparam int RX_CW = srtrb_pkg::RX_CW;

	function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(srtrb_pkg::RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
		return (p == TX_AW'(srtrb_pkg::TX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [7:0]       rx_mem [srtrb_pkg::RX_DEPTH];
	logic [7:0]       tx_mem [srtrb_pkg::TX_DEPTH];
	logic [7:0]       rx_rd_q;
	logic [7:0]       tx_rd_q;
	logic [RX_AW-1:0] rx_head_q;
	logic [RX_AW-1:0] rx_tail_q;
	logic [RX_CW-1:0] rx_count_q;
	logic [2:0]       sticky_q;
	logic [TX_AW-1:0] tx_head_q;
	logic [TX_AW-1:0] tx_tail_q;
	logic             irq_q;

	logic             rd_valid_s1;
	logic             sd_valid_s1;
	logic             wr_ok_s1;
	logic             wr_full_s1;
	srtrb_pkg::out_item_t result_q;

	logic [RX_AW-1:0] rx_head_nx;
	logic [RX_AW-1:0] rx_tail_nx;
	logic [TX_AW-1:0] tx_head_nx;
	logic [TX_AW-1:0] tx_tail_nx;
	logic [2:0]       in_errs;
	logic             rx_clear;
	logic             rx_nonempty;
	logic             tx_full;
	logic             tx_nonempty;
	logic             do_rx_store;
	logic             rx_good;
	logic             do_clear;
	logic             do_read;
	logic             do_write;
	logic             do_full;
	logic             do_send;
	logic             do_tx_idle;

	// Decode the event against the current ring state
	always_comb begin
		rx_head_nx  = rx_next(rx_head_q);
		rx_tail_nx  = rx_next(rx_tail_q);
		tx_head_nx  = tx_next(tx_head_q);
		tx_tail_nx  = tx_next(tx_tail_q);
		in_errs     = (item.framing_error ? srtrb_pkg::ERR_FRAMING : 3'b000) |
			(item.line_overrun ? srtrb_pkg::ERR_LINE : 3'b000);
		rx_clear    = (sticky_q != 3'b000);
		rx_nonempty = (rx_head_q != rx_tail_q);
		tx_full     = (tx_head_nx == tx_tail_q);
		tx_nonempty = (tx_head_q != tx_tail_q);
		do_rx_store = cmd.accept && (item.op == srtrb_pkg::OP_RX_BYTE);
		rx_good     = do_rx_store && (in_errs == 3'b000);
		do_clear    = cmd.accept && (item.op == srtrb_pkg::OP_HOST_READ) && rx_clear;
		do_read     = cmd.accept && (item.op == srtrb_pkg::OP_HOST_READ) && !rx_clear &&
			rx_nonempty;
		do_write    = cmd.accept && (item.op == srtrb_pkg::OP_HOST_WRITE) &&
			transmit_enable && !tx_full;
		do_full     = cmd.accept && (item.op == srtrb_pkg::OP_HOST_WRITE) &&
			transmit_enable && tx_full;
		do_send     = cmd.accept && (item.op == srtrb_pkg::OP_TX_READY) && tx_nonempty;
		do_tx_idle  = cmd.accept && (item.op == srtrb_pkg::OP_TX_READY) && !tx_nonempty;
	end

	// Receive ring pointers, level and sticky errors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			rx_count_q <= '0;
			sticky_q   <= 3'b000;
		end else begin
			if (rx_good) begin
				rx_head_q <= rx_head_nx;
				if (rx_count_q < RX_CW'(srtrb_pkg::RX_DEPTH)) rx_count_q <= rx_count_q + 1'b1;
			end
			if (do_rx_store) begin
				sticky_q <= sticky_q | in_errs |
					((rx_good && (rx_head_nx == rx_tail_q)) ? srtrb_pkg::ERR_SOFT : 3'b000);
			end
			if (do_clear) begin
				sticky_q   <= 3'b000;
				rx_tail_q  <= rx_head_q;
				rx_count_q <= '0;
			end
			if (do_read) begin
				rx_tail_q <= rx_tail_nx;
				if (rx_count_q != '0) rx_count_q <= rx_count_q - 1'b1;
			end
		end
	end

	// Transmit ring pointers and interrupt enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q <= '0;
			tx_tail_q <= '0;
			irq_q     <= 1'b0;
		end else begin
			if (do_write) begin
				tx_head_q <= tx_head_nx;
				irq_q     <= 1'b1;
			end
			if (do_send) tx_tail_q <= tx_tail_nx;
			if (do_tx_idle) irq_q <= 1'b0;
		end
	end

	// Ring memories with registered read data
	always_ff @(posedge clk) begin
		if (do_rx_store) rx_mem[rx_head_q] <= item.data_byte;
		if (do_read) rx_rd_q <= rx_mem[rx_tail_q];
	end

	always_ff @(posedge clk) begin
		if (do_write) tx_mem[tx_head_q] <= item.data_byte;
		if (do_send) tx_rd_q <= tx_mem[tx_tail_q];
	end

	// Event outcome, held until the output register loads
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_valid_s1 <= do_read;
			sd_valid_s1 <= do_send;
			wr_ok_s1    <= do_write;
			wr_full_s1  <= do_full;
		end
	end

	// Output register; status is sampled before the next event lands
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			result_q.read_byte         <= rd_valid_s1 ? rx_rd_q : 8'h00;
			result_q.read_valid        <= rd_valid_s1;
			result_q.send_byte         <= sd_valid_s1 ? tx_rd_q : 8'h00;
			result_q.send_valid        <= sd_valid_s1;
			result_q.write_accepted    <= wr_ok_s1;
			result_q.write_full        <= wr_full_s1;
			result_q.transmit_irq_on   <= irq_q;
			result_q.receive_available <= rx_nonempty;
			result_q.receive_level     <= rx_count_q;
			result_q.error_flags       <= sticky_q;
		end
	end

	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_level_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= RX_CW'(srtrb_pkg::RX_DEPTH))
		else $error("receive level beyond ring depth");
	a_write_arms_irq: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> irq_q)
		else $error("queued write left transmit interrupt off");
	a_tx_one_free: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> (tx_head_q != tx_tail_q))
		else $error("transmit ring wrapped onto its tail");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		do_clear |=> ((rx_head_q == rx_tail_q) && (sticky_q == 3'b000)))
		else $error("error clear did not empty the receive ring");
`endif

endmodule

// ----- dv/srtrb_checker.sv -----
`timescale 1ns / 1ps

// Passive scoreboard: tracks the ring state from the event channel and the
// register port, and compares every result transaction with its prediction.
module srtrb_checker
	import srtrb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	srtrb_in_if                in_ch,
	srtrb_out_if               out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 pending,
	output int                 checked,
	output int                 bytes_read,
	output int                 bytes_sent,
	output int                 writes_full,
	output int                 writes_dropped,
	output int                 soft_overruns,
	output int                 bad_bytes
);

	// Shadow copy of both rings and the control state
	logic [7:0]       rx_ring [RX_DEPTH];
	logic [RX_AW-1:0] rx_wr;
	logic [RX_AW-1:0] rx_rd;
	logic [RX_CW-1:0] rx_level;
	logic [2:0]       line_errs;
	logic [7:0]       tx_ring [TX_DEPTH];
	logic [TX_AW-1:0] tx_wr;
	logic [TX_AW-1:0] tx_rd;
	logic             irq_on;
	logic             tx_en;

	out_item_t results_due[$];

	function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
		return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Advance the shadow state by one event and form the status it reports
	task automatic apply_event(input in_item_t ev, output out_item_t r);
		logic [2:0]       errs;
		logic [TX_AW-1:0] nxt;
		r = '0;
		errs = (ev.framing_error ? ERR_FRAMING : 3'b000) | (ev.line_overrun ? ERR_LINE : 3'b000);
		case (ev.op)
			OP_RX_BYTE: begin
				rx_ring[rx_wr] = ev.data_byte;
				line_errs = line_errs | errs;
				if (errs != 3'b000) begin
					bad_bytes++;
				end else begin
					if (rx_level < RX_CW'(RX_DEPTH))
						rx_level = rx_level + 1'b1;
					rx_wr = rx_next(rx_wr);
					if (rx_wr == rx_rd) begin
						if ((line_errs & ERR_SOFT) == 3'b000)
							soft_overruns++;
						line_errs = line_errs | ERR_SOFT;
					end
				end
			end
			OP_HOST_READ: begin
				// any error flag flushes the ring before the read
				if (line_errs != 3'b000) begin
					line_errs = 3'b000;
					rx_rd = rx_wr;
					rx_level = '0;
				end
				if (rx_rd != rx_wr) begin
					r.read_byte = rx_ring[rx_rd];
					r.read_valid = 1'b1;
					rx_rd = rx_next(rx_rd);
					if (rx_level != '0)
						rx_level = rx_level - 1'b1;
				end
			end
			OP_HOST_WRITE: begin
				if (!tx_en) begin
					writes_dropped++;
				end else begin
					nxt = tx_next(tx_wr);
					if (nxt == tx_rd) begin
						r.write_full = 1'b1;
						writes_full++;
					end else begin
						tx_ring[tx_wr] = ev.data_byte;
						tx_wr = nxt;
						irq_on = 1'b1;
						r.write_accepted = 1'b1;
					end
				end
			end
			default: begin
				if (tx_rd != tx_wr) begin
					r.send_byte = tx_ring[tx_rd];
					r.send_valid = 1'b1;
					tx_rd = tx_next(tx_rd);
				end else begin
					irq_on = 1'b0;
				end
			end
		endcase
		r.transmit_irq_on = irq_on;
		r.receive_available = (rx_wr != rx_rd);
		r.receive_level = rx_level;
		r.error_flags = line_errs;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		in_item_t  ev;
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			for (int i = 0; i < RX_DEPTH; i++) rx_ring[i] = '0;
			for (int i = 0; i < TX_DEPTH; i++) tx_ring[i] = '0;
			rx_wr = '0;
			rx_rd = '0;
			rx_level = '0;
			line_errs = '0;
			tx_wr = '0;
			tx_rd = '0;
			irq_on = 1'b0;
			tx_en = 1'b1;
			results_due.delete();
			pending <= 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready &&
					paddr[PADDR_W-1:2] == REG_TRANSMIT_ENABLE)
				tx_en = pwdata[0];

			// compare a finished transaction with the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				got.read_byte = out_ch.read_byte;
				got.read_valid = out_ch.read_valid;
				got.send_byte = out_ch.send_byte;
				got.send_valid = out_ch.send_valid;
				got.write_accepted = out_ch.write_accepted;
				got.write_full = out_ch.write_full;
				got.transmit_irq_on = out_ch.transmit_irq_on;
				got.receive_available = out_ch.receive_available;
				got.receive_level = out_ch.receive_level;
				got.error_flags = out_ch.error_flags;
				if (results_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, actual %0h", $time, got);
				end else begin
					want = results_due.pop_front();
					check_field("read_byte", want.read_byte, got.read_byte);
					check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
					check_field("send_byte", want.send_byte, got.send_byte);
					check_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
					check_field("write_accepted", 8'(want.write_accepted),
						8'(got.write_accepted));
					check_field("write_full", 8'(want.write_full), 8'(got.write_full));
					check_field("transmit_irq_on", 8'(want.transmit_irq_on),
						8'(got.transmit_irq_on));
					check_field("receive_available", 8'(want.receive_available),
						8'(got.receive_available));
					check_field("receive_level", 8'(want.receive_level),
						8'(got.receive_level));
					check_field("error_flags", 8'(want.error_flags), 8'(got.error_flags));
					if (want.read_valid) bytes_read++;
					if (want.send_valid) bytes_sent++;
				end
				checked++;
			end

			// predict the result of an accepted event
			if (in_ch.valid && in_ch.ready) begin
				ev.op = in_ch.op;
				ev.data_byte = in_ch.data_byte;
				ev.framing_error = in_ch.framing_error;
				ev.line_overrun = in_ch.line_overrun;
				apply_event(ev, want);
				results_due.push_back(want);
			end
			pending <= results_due.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import srtrb_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatches;
	int pending;
	int checked;
	int bytes_read;
	int bytes_sent;
	int writes_full;
	int writes_dropped;
	int soft_overruns;
	int bad_bytes;

	int events_sent;
	int burst_left;
	bit gaps_on;
	int hold_req;

	srtrb_in_if  in_ch();
	srtrb_out_if out_ch();

	serial_rx_tx_ring_buffers dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	srtrb_checker scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatches     (mismatches),
		.pending        (pending),
		.checked        (checked),
		.bytes_read     (bytes_read),
		.bytes_sent     (bytes_sent),
		.writes_full    (writes_full),
		.writes_dropped (writes_dropped),
		.soft_overruns  (soft_overruns),
		.bad_bytes      (bad_bytes)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one event, with a random gap at the start of some bursts while gaps_on is set
	task automatic send_event(input op_t op, input logic [7:0] b, input logic fe,
			input logic lo);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 16);
			if (gaps_on && $urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 7);
		end
		burst_left--;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.data_byte <= b;
		in_ch.framing_error <= fe;
		in_ch.line_overrun <= lo;
		do @(posedge clk); while (!in_ch.ready);
		events_sent++;
	endtask

	// Drop valid and wait until every result has come back
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic en);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & ~32'h1) | {31'd0, en};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random traffic built mostly from runs of one kind of event
	task automatic run_traffic(input int n_events);
		int target;
		int len;
		int kind;
		logic [1:0] errs;
		target = events_sent + n_events;
		while (events_sent < target) begin
			kind = $urandom_range(0, 9);
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				errs = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
				case (kind)
					0, 1: send_event(OP_RX_BYTE, 8'($urandom), errs[0], errs[1]);
					2, 3: send_event(OP_HOST_READ, 8'($urandom), 1'($urandom), 1'($urandom));
					4, 5: send_event(OP_HOST_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
					6, 7: send_event(OP_TX_READY, 8'($urandom), 1'($urandom), 1'($urandom));
					default: begin
						if (i < 10)
							send_event(op_t'(2'($urandom_range(0, 3))), 8'($urandom),
								1'($urandom), 1'($urandom));
					end
				endcase
			end
		end
	endtask

	// Result consumer: stall patterns that change over time, plus long holds on request
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int hold_done;
		int cyc;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		hold_done = 0;
		cyc = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				hold_left = $urandom_range(60, 100);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom);
					2: out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: out_ch.ready <= ((cyc % 7) < 4);
				endcase
			end
		end
	end

	// Stop a hung run
	initial begin
		#3_000_000;
		$display("serial_rx_tx_ring_buffers: mismatch");
		$finish;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = OP_RX_BYTE;
		in_ch.data_byte = '0;
		in_ch.framing_error = 1'b0;
		in_ch.line_overrun = 1'b0;
		events_sent = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_req = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_write(REG_TRANSMIT_ENABLE, 1'b1);

		// directed: empty reads, byte extremes, line errors, flush, tx drain
		send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
		send_event(OP_TX_READY, 8'h00, 1'b0, 1'b0);
		send_event(OP_RX_BYTE, 8'h00, 1'b0, 1'b0);
		send_event(OP_RX_BYTE, 8'hFF, 1'b0, 1'b0);
		send_event(OP_HOST_READ, 8'hFF, 1'b1, 1'b1);
		send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
		send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
		send_event(OP_RX_BYTE, 8'hA5, 1'b1, 1'b0);
		send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
		send_event(OP_RX_BYTE, 8'h3C, 1'b0, 1'b1);
		send_event(OP_RX_BYTE, 8'hC3, 1'b1, 1'b1);
		send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
		send_event(OP_RX_BYTE, 8'h81, 1'b0, 1'b0);
		send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
		send_event(OP_HOST_WRITE, 8'hFF, 1'b0, 1'b0);
		send_event(OP_HOST_WRITE, 8'h00, 1'b0, 1'b0);
		send_event(OP_TX_READY, 8'hFF, 1'b1, 1'b1);
		send_event(OP_TX_READY, 8'h00, 1'b0, 1'b0);
		send_event(OP_TX_READY, 8'h00, 1'b0, 1'b0);
		send_event(OP_HOST_WRITE, 8'h7E, 1'b1, 1'b1);
		send_event(OP_TX_READY, 8'h00, 1'b0, 1'b0);
		settle();

		// transmitter off: host writes fall away
		reg_write(REG_TRANSMIT_ENABLE, 1'b0);
		run_traffic(150);
		settle();

		// transmitter on, with one long consumer hold under back-to-back traffic
		reg_write(REG_TRANSMIT_ENABLE, 1'b1);
		gaps_on = 1'b0;
		hold_req++;
		run_traffic(40);
		gaps_on = 1'b1;
		run_traffic(310);
		settle();

		reg_write(REG_TRANSMIT_ENABLE, 1'b0);
		run_traffic(80);
		settle();

		reg_write(REG_TRANSMIT_ENABLE, 1'b1);
		run_traffic(300);
		settle();

		$display("ran %0d events, checked %0d results: %0d bytes read back, %0d sent",
			events_sent, checked, bytes_read, bytes_sent);
		$display("%0d full rejects, %0d writes dropped, %0d bad line bytes, %0d sw overruns",
			writes_full, writes_dropped, bad_bytes, soft_overruns);
		if (mismatches == 0 && pending == 0) begin
			$display("serial_rx_tx_ring_buffers: match");
		end else begin
			$display("serial_rx_tx_ring_buffers: mismatch");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/srtrb_pkg.sv
rtl/srtrb_if.sv
rtl/srtrb_ctrl.sv
rtl/srtrb_datapath.sv
rtl/serial_rx_tx_ring_buffers.sv
dv/srtrb_checker.sv
dv/tb.sv
